/* hw/rtl/wlpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint path follower package
// Shared types, codes and constants of the path follower.
// ----------------------------------------------------------------------------
package wlpf_pkg;

	localparam logic [1:0] OPC_LOAD    = 2'd0;
	localparam logic [1:0] OPC_TICK    = 2'd1;
	localparam logic [1:0] OPC_RESTART = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_FEW  = 2'd2;

	localparam logic [31:0] SPAN_RESET = 32'd1000;
	localparam int LEN_W = 40;

	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic        [31:0] time_ms;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic        [3:0]  segment;
		logic               finished;
		logic        [1:0]  status;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_LOAD_AB, S_SQ, S_SQRT, S_ACC, S_SPD, S_SPD_SET,
		S_SEG_R0, S_SEG_R1, S_SEG_R2, S_DIR_INIT, S_DIR_DIV, S_DIR_SET, S_SEG_END,
		S_MUL1, S_MUL2, S_UPD, S_CHK, S_CHK_W, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_CAPTURE, DP_LOAD_FULL, DP_LOAD_WR, DP_LOAD_AB, DP_SQ,
		DP_SQRT_STEP, DP_ACC, DP_SHORT, DP_SPD_INIT, DP_DIV_STEP, DP_SPD_SET,
		DP_SEG_R0, DP_SEG_R1, DP_SEG_R2, DP_DIR_INIT, DP_DIR_SET, DP_SEG_END,
		DP_TICK_FIRST, DP_TICK_START, DP_MUL1, DP_MUL2, DP_UPD, DP_CHK_RD,
		DP_SNAP, DP_NEXT, DP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       full;
		logic       few;
		logic       count_zero;
		logic       done;
		logic       first;
		logic       nxt_lt;
		logic       last;
		logic       passed;
	} stat_t;

endpackage

/* hw/rtl/wlpf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path follower channels
// Valid/ready channels for input items, results and the span register.
// ----------------------------------------------------------------------------
interface wlpf_item_if;
	logic            valid;
	logic            ready;
	wlpf_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wlpf_result_if;
	logic              valid;
	logic              ready;
	wlpf_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wlpf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/wlpf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path follower controller
// Sequences loads, ticks and restarts through the datapath and owns the
// input and result handshakes.
// ----------------------------------------------------------------------------
module wlpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  wlpf_pkg::stat_t   stat,
	output wlpf_pkg::cmd_t    cmd
);

	wlpf_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [1:0] axis_q, axis_d;
	logic       ctx_load_q, ctx_load_d;
	logic       out_valid_q;
	logic       publish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wlpf_pkg::S_IDLE;
			cnt_q       <= '0;
			axis_q      <= '0;
			ctx_load_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			axis_q     <= axis_d;
			ctx_load_q <= ctx_load_d;
			if (publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		axis_d     = axis_q;
		ctx_load_d = ctx_load_q;
		case (state_q)
			wlpf_pkg::S_IDLE: begin
				if (in_valid)
					state_d = wlpf_pkg::S_DISPATCH;
			end
			wlpf_pkg::S_DISPATCH: begin
				axis_d = '0;
				cnt_d  = '0;
				case (stat.opcode)
					wlpf_pkg::OPC_LOAD: begin
						if (stat.full || stat.count_zero)
							state_d = wlpf_pkg::S_DONE;
						else
							state_d = wlpf_pkg::S_LOAD_AB;
					end
					wlpf_pkg::OPC_TICK: begin
						if (stat.done || stat.first)
							state_d = wlpf_pkg::S_DONE;
						else
							state_d = wlpf_pkg::S_MUL1;
					end
					wlpf_pkg::OPC_RESTART: begin
						if (stat.few)
							state_d = wlpf_pkg::S_DONE;
						else
							state_d = wlpf_pkg::S_SPD;
					end
					default: state_d = wlpf_pkg::S_DONE;
				endcase
			end
			wlpf_pkg::S_LOAD_AB: begin
				ctx_load_d = 1'b1;
				axis_d     = '0;
				state_d    = wlpf_pkg::S_SQ;
			end
			wlpf_pkg::S_SQ: begin
				cnt_d = '0;
				if (axis_q == 2'd2)
					state_d = wlpf_pkg::S_SQRT;
				else
					axis_d = axis_q + 2'd1;
			end
			wlpf_pkg::S_SQRT: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					axis_d  = '0;
					state_d = ctx_load_q ? wlpf_pkg::S_ACC : wlpf_pkg::S_DIR_INIT;
				end
			end
			wlpf_pkg::S_ACC: state_d = wlpf_pkg::S_DONE;
			wlpf_pkg::S_SPD: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd55)
					state_d = wlpf_pkg::S_SPD_SET;
			end
			wlpf_pkg::S_SPD_SET: state_d = wlpf_pkg::S_SEG_R0;
			wlpf_pkg::S_SEG_R0: state_d = wlpf_pkg::S_SEG_R1;
			wlpf_pkg::S_SEG_R1: state_d = wlpf_pkg::S_SEG_R2;
			wlpf_pkg::S_SEG_R2: begin
				ctx_load_d = 1'b0;
				axis_d     = '0;
				state_d    = wlpf_pkg::S_SQ;
			end
			wlpf_pkg::S_DIR_INIT: begin
				cnt_d   = '0;
				state_d = wlpf_pkg::S_DIR_DIV;
			end
			wlpf_pkg::S_DIR_DIV: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd30)
					state_d = wlpf_pkg::S_DIR_SET;
			end
			wlpf_pkg::S_DIR_SET: begin
				if (axis_q == 2'd2) begin
					state_d = wlpf_pkg::S_SEG_END;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = wlpf_pkg::S_DIR_INIT;
				end
			end
			wlpf_pkg::S_SEG_END: state_d = wlpf_pkg::S_DONE;
			wlpf_pkg::S_MUL1: state_d = wlpf_pkg::S_MUL2;
			wlpf_pkg::S_MUL2: state_d = wlpf_pkg::S_UPD;
			wlpf_pkg::S_UPD: begin
				if (axis_q == 2'd2) begin
					state_d = wlpf_pkg::S_CHK;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = wlpf_pkg::S_MUL1;
				end
			end
			wlpf_pkg::S_CHK: begin
				state_d = stat.nxt_lt ? wlpf_pkg::S_CHK_W : wlpf_pkg::S_DONE;
			end
			wlpf_pkg::S_CHK_W: begin
				if (stat.passed && !stat.last)
					state_d = wlpf_pkg::S_SEG_R0;
				else
					state_d = wlpf_pkg::S_DONE;
			end
			wlpf_pkg::S_DONE: begin
				if (!out_valid_q || out_ready)
					state_d = wlpf_pkg::S_IDLE;
			end
			default: state_d = wlpf_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = wlpf_pkg::DP_NOP;
		cmd.axis = axis_q;
		publish  = 1'b0;
		case (state_q)
			wlpf_pkg::S_IDLE: begin
				if (in_valid)
					cmd.op = wlpf_pkg::DP_CAPTURE;
			end
			wlpf_pkg::S_DISPATCH: begin
				case (stat.opcode)
					wlpf_pkg::OPC_LOAD:
						cmd.op = stat.full ? wlpf_pkg::DP_LOAD_FULL : wlpf_pkg::DP_LOAD_WR;
					wlpf_pkg::OPC_TICK: begin
						if (!stat.done)
							cmd.op = stat.first ? wlpf_pkg::DP_TICK_FIRST
								: wlpf_pkg::DP_TICK_START;
					end
					wlpf_pkg::OPC_RESTART:
						cmd.op = stat.few ? wlpf_pkg::DP_SHORT : wlpf_pkg::DP_SPD_INIT;
					default: cmd.op = wlpf_pkg::DP_NOP;
				endcase
			end
			wlpf_pkg::S_LOAD_AB: cmd.op = wlpf_pkg::DP_LOAD_AB;
			wlpf_pkg::S_SQ: cmd.op = wlpf_pkg::DP_SQ;
			wlpf_pkg::S_SQRT: cmd.op = wlpf_pkg::DP_SQRT_STEP;
			wlpf_pkg::S_ACC: cmd.op = wlpf_pkg::DP_ACC;
			wlpf_pkg::S_SPD: cmd.op = wlpf_pkg::DP_DIV_STEP;
			wlpf_pkg::S_SPD_SET: cmd.op = wlpf_pkg::DP_SPD_SET;
			wlpf_pkg::S_SEG_R0: cmd.op = wlpf_pkg::DP_SEG_R0;
			wlpf_pkg::S_SEG_R1: cmd.op = wlpf_pkg::DP_SEG_R1;
			wlpf_pkg::S_SEG_R2: cmd.op = wlpf_pkg::DP_SEG_R2;
			wlpf_pkg::S_DIR_INIT: cmd.op = wlpf_pkg::DP_DIR_INIT;
			wlpf_pkg::S_DIR_DIV: cmd.op = wlpf_pkg::DP_DIV_STEP;
			wlpf_pkg::S_DIR_SET: cmd.op = wlpf_pkg::DP_DIR_SET;
			wlpf_pkg::S_SEG_END: cmd.op = wlpf_pkg::DP_SEG_END;
			wlpf_pkg::S_MUL1: cmd.op = wlpf_pkg::DP_MUL1;
			wlpf_pkg::S_MUL2: cmd.op = wlpf_pkg::DP_MUL2;
			wlpf_pkg::S_UPD: cmd.op = wlpf_pkg::DP_UPD;
			wlpf_pkg::S_CHK: begin
				if (stat.nxt_lt)
					cmd.op = wlpf_pkg::DP_CHK_RD;
			end
			wlpf_pkg::S_CHK_W: begin
				if (stat.passed)
					cmd.op = stat.last ? wlpf_pkg::DP_SNAP : wlpf_pkg::DP_NEXT;
			end
			wlpf_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = wlpf_pkg::DP_PUBLISH;
					publish = 1'b1;
				end
			end
			default: cmd.op = wlpf_pkg::DP_NOP;
		endcase
	end

	assign in_ready  = (state_q == wlpf_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/wlpf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path follower datapath
// Waypoint memory, path state, shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
module wlpf_datapath #(
	parameter int MAX_POINTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wlpf_pkg::cmd_t    cmd,
	output wlpf_pkg::stat_t   stat,
	input  wlpf_pkg::item_t   item_data,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	output wlpf_pkg::result_t result_data
);

	localparam int SW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LW = wlpf_pkg::LEN_W;

	logic [95:0] mem [MAX_POINTS];
	logic [95:0] rd_q;
	logic [SW-1:0] rd_addr;

	wlpf_pkg::item_t   in_q;
	wlpf_pkg::result_t res_q;
	logic [CW-1:0]     count_q;
	logic [LW-1:0]     path_q;
	logic [31:0]       speed_q, span_q, start_q, prev_q, interval_q;
	logic [SW-1:0]     seg_q;
	logic signed [31:0] cur_q [3];
	logic signed [31:0] dir_q [3];
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic              first_q, done_q;
	logic [1:0]        status_q;

	logic [65:0] sum_q, rad_q, prod_q;
	logic [35:0] srem_q;
	logic [32:0] root_q;
	logic [32:0] drem_q, den_q;
	logic [55:0] num_q, quo_q;

	logic [1:0]  ax;
	logic signed [32:0] d_ax;
	logic [32:0] m_ax;
	logic [31:0] dmag;
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p, sum_next;
	logic [35:0] srem_n, strial;
	logic [33:0] dr2;
	logic [CW-1:0] nxt;
	logic [CW:0] nxt2;
	logic [LW:0] path_sum;
	logic signed [50:0] upd_p;
	logic signed [31:0] upd_sat, rd_c [3], dir_new;
	logic [30:0] q31;
	logic [32:0] t_el;
	logic pass_any;
	logic [SW+3:0] seg_ext;

	assign ax   = cmd.axis;
	assign d_ax = {b_q[ax][31], b_q[ax]} - {a_q[ax][31], a_q[ax]};
	assign m_ax = d_ax[32] ? 33'(-d_ax) : 33'(d_ax);
	assign dmag = dir_q[ax][31] ? 32'(-dir_q[ax]) : 32'(dir_q[ax]);
	assign nxt  = CW'(seg_q) + CW'(1);
	assign nxt2 = {1'b0, nxt} + (CW+1)'(1);
	assign rd_c[0] = rd_q[95:64];
	assign rd_c[1] = rd_q[63:32];
	assign rd_c[2] = rd_q[31:0];
	assign seg_ext = {4'b0, seg_q};

	always_comb begin
		case (cmd.op)
			wlpf_pkg::DP_MUL1: begin
				mul_a = {1'b0, dmag};
				mul_b = {1'b0, speed_q};
			end
			wlpf_pkg::DP_MUL2: begin
				mul_a = prod_q[62:30];
				mul_b = {1'b0, interval_q};
			end
			default: begin
				mul_a = m_ax;
				mul_b = m_ax;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		case (cmd.op)
			wlpf_pkg::DP_LOAD_WR: rd_addr = SW'(count_q - CW'(1));
			wlpf_pkg::DP_SEG_R0: rd_addr = seg_q;
			default: rd_addr = nxt[SW-1:0];
		endcase
	end

	assign sum_next = (ax == 2'd0 ? 66'd0 : sum_q) + mul_p;
	assign srem_n   = {srem_q[33:0], rad_q[65:64]};
	assign strial   = {1'b0, root_q, 2'b01};
	assign dr2      = {drem_q, num_q[55]};
	assign path_sum = {1'b0, path_q} + (LW+1)'(root_q);
	assign upd_p    = dir_q[ax][31] ? (51'(cur_q[ax]) - $signed({2'b0, prod_q[64:16]}))
		: (51'(cur_q[ax]) + $signed({2'b0, prod_q[64:16]}));
	assign q31      = quo_q[30:0];
	assign dir_new  = (root_q == '0) ? 32'sd0
		: (d_ax[32] ? -$signed({1'b0, q31}) : $signed({1'b0, q31}));
	assign t_el     = {1'b0, in_q.time_ms - start_q};

	always_comb begin
		if (upd_p > 51'sd2147483647)
			upd_sat = 32'sh7fffffff;
		else if (upd_p < -51'sd2147483648)
			upd_sat = 32'sh80000000;
		else
			upd_sat = upd_p[31:0];
	end

	always_comb begin
		pass_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (dir_q[i] > 0 && cur_q[i] > rd_c[i])
				pass_any = 1'b1;
			if (dir_q[i] < 0 && cur_q[i] < rd_c[i])
				pass_any = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == wlpf_pkg::DP_LOAD_WR)
			mem[count_q[SW-1:0]] <= {in_q.point_x, in_q.point_y, in_q.point_z};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= wlpf_pkg::SPAN_RESET;
			count_q  <= '0;
			path_q   <= '0;
			speed_q  <= '0;
			seg_q    <= '0;
			start_q  <= '0;
			prev_q   <= '0;
			first_q  <= 1'b1;
			done_q   <= 1'b1;
			status_q <= wlpf_pkg::STATUS_OK;
			for (int i = 0; i < 3; i++) begin
				cur_q[i] <= '0;
				dir_q[i] <= '0;
			end
		end else begin
			if (cfg_we)
				span_q <= cfg_data;
			case (cmd.op)
				wlpf_pkg::DP_CAPTURE: status_q <= wlpf_pkg::STATUS_OK;
				wlpf_pkg::DP_LOAD_FULL: status_q <= wlpf_pkg::STATUS_FULL;
				wlpf_pkg::DP_SHORT: status_q <= wlpf_pkg::STATUS_FEW;
				wlpf_pkg::DP_LOAD_WR: begin
					if (count_q == '0)
						count_q <= CW'(1);
				end
				wlpf_pkg::DP_ACC: begin
					path_q  <= path_sum[LW] ? '1 : path_sum[LW-1:0];
					count_q <= count_q + CW'(1);
				end
				wlpf_pkg::DP_SPD_SET: begin
					if (span_q == '0)
						speed_q <= '0;
					else
						speed_q <= (|quo_q[55:32]) ? '1 : quo_q[31:0];
					seg_q   <= '0;
					first_q <= 1'b1;
					done_q  <= 1'b0;
				end
				wlpf_pkg::DP_DIR_SET: dir_q[ax] <= dir_new;
				wlpf_pkg::DP_SEG_END: begin
					for (int i = 0; i < 3; i++)
						cur_q[i] <= a_q[i];
				end
				wlpf_pkg::DP_TICK_FIRST: begin
					prev_q  <= in_q.time_ms;
					start_q <= in_q.time_ms;
					first_q <= 1'b0;
				end
				wlpf_pkg::DP_TICK_START: begin
					if (t_el > {1'b0, span_q})
						done_q <= 1'b1;
					prev_q <= in_q.time_ms;
				end
				wlpf_pkg::DP_UPD: cur_q[ax] <= upd_sat;
				wlpf_pkg::DP_SNAP: begin
					for (int i = 0; i < 3; i++)
						cur_q[i] <= rd_c[i];
					done_q <= 1'b1;
				end
				wlpf_pkg::DP_NEXT: seg_q <= nxt[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			wlpf_pkg::DP_CAPTURE: in_q <= item_data;
			wlpf_pkg::DP_TICK_START: interval_q <= in_q.time_ms - prev_q;
			wlpf_pkg::DP_LOAD_AB: begin
				a_q[0] <= rd_c[0];
				a_q[1] <= rd_c[1];
				a_q[2] <= rd_c[2];
				b_q[0] <= in_q.point_x;
				b_q[1] <= in_q.point_y;
				b_q[2] <= in_q.point_z;
			end
			wlpf_pkg::DP_SEG_R1: begin
				for (int i = 0; i < 3; i++)
					a_q[i] <= rd_c[i];
			end
			wlpf_pkg::DP_SEG_R2: begin
				for (int i = 0; i < 3; i++)
					b_q[i] <= rd_c[i];
			end
			wlpf_pkg::DP_SQ: begin
				sum_q  <= sum_next;
				rad_q  <= sum_next;
				srem_q <= '0;
				root_q <= '0;
			end
			wlpf_pkg::DP_SQRT_STEP: begin
				rad_q <= {rad_q[63:0], 2'b00};
				if (srem_n >= strial) begin
					srem_q <= srem_n - strial;
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					srem_q <= srem_n;
					root_q <= {root_q[31:0], 1'b0};
				end
			end
			wlpf_pkg::DP_SPD_INIT: begin
				drem_q <= '0;
				num_q  <= {path_q, 16'b0};
				quo_q  <= '0;
				den_q  <= {1'b0, span_q};
			end
			wlpf_pkg::DP_DIR_INIT: begin
				drem_q <= {1'b0, m_ax[32:1]};
				num_q  <= {m_ax[0], 55'b0};
				quo_q  <= '0;
				den_q  <= root_q;
			end
			wlpf_pkg::DP_DIV_STEP: begin
				num_q <= {num_q[54:0], 1'b0};
				if (dr2 >= {1'b0, den_q}) begin
					drem_q <= 33'(dr2 - {1'b0, den_q});
					quo_q  <= {quo_q[54:0], 1'b1};
				end else begin
					drem_q <= dr2[32:0];
					quo_q  <= {quo_q[54:0], 1'b0};
				end
			end
			wlpf_pkg::DP_MUL1, wlpf_pkg::DP_MUL2: prod_q <= mul_p;
			wlpf_pkg::DP_PUBLISH: begin
				res_q.pos_x    <= cur_q[0];
				res_q.pos_y    <= cur_q[1];
				res_q.pos_z    <= cur_q[2];
				res_q.segment  <= seg_ext[3:0];
				res_q.finished <= done_q;
				res_q.status   <= status_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.opcode     = in_q.opcode;
		stat.full       = (count_q >= CW'(MAX_POINTS));
		stat.few        = (count_q < CW'(2));
		stat.count_zero = (count_q == '0);
		stat.done       = done_q;
		stat.first      = first_q;
		stat.nxt_lt     = (nxt < count_q);
		stat.last       = (nxt2 >= {1'b0, count_q});
		stat.passed     = pass_any;
	end

	assign result_data = res_q;

endmodule

/* hw/rtl/waypoint_linear_path_follower.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint linear path follower
// Moves a point along a polyline of loaded waypoints at constant speed.
// ----------------------------------------------------------------------------
// One item is worked on at a time and each gives one result beat. A load is
// paced by the one-bit-per-cycle square root of the segment length; the first
// load, a load into a full table, a restart with too few waypoints, a first
// tick, a tick after the end and an unknown opcode go straight to the result.
// A tick otherwise runs the shared multiplier, plus the segment setup when it
// enters a new segment. A restart runs a 56-step speed division, the square
// root and three 31-step direction divisions on the one shared divider. The
// next item is taken while a result still waits in the output register.
module waypoint_linear_path_follower #(
	parameter int MAX_POINTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wlpf_item_if.sink    item,
	wlpf_result_if.source result,
	wlpf_cfg_if.sink     cfg
);

	wlpf_pkg::cmd_t  cmd;
	wlpf_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	wlpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wlpf_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item_data   (item.data),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.result_data (result.data)
	);

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("input taken while an item is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.status == wlpf_pkg::STATUS_OK ||
			result.data.status == wlpf_pkg::STATUS_FULL ||
			result.data.status == wlpf_pkg::STATUS_FEW))
		else $error("result status is not a defined code");

	a_short_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.status == wlpf_pkg::STATUS_FEW
		|-> result.data.finished)
		else $error("short path result is not finished");
`endif

endmodule
